[src/rrd_pkg.sv]
// Shared types, constants and helpers for the repetition run detector.
package rrd_pkg;

   localparam int SHORT_TOKEN_MAX_DEF = 8;
   localparam int COUNT_BITS_DEF      = 16;
   localparam int OUT_BITS            = 16;

   localparam logic [OUT_BITS-1:0] BYTE_RUN_LIMIT_RESET  = 16'd35;
   localparam logic [OUT_BITS-1:0] TOKEN_RUN_LIMIT_RESET = 16'd8;

   localparam logic [7:0] SEP_SPACE = 8'h20;
   localparam logic [7:0] SEP_TAB   = 8'h09;
   localparam logic [7:0] SEP_LF    = 8'h0A;
   localparam logic [7:0] SEP_CR    = 8'h0D;

   typedef enum logic [0:0] {
      CSR_BYTE_RUN_LIMIT  = 1'b0,
      CSR_TOKEN_RUN_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_last;
   } req_word_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] longest_byte_run;
      logic [OUT_BITS-1:0] longest_token_repeat;
      logic                is_degenerate;
   } rsp_word_type;

   function automatic logic is_separator(logic [7:0] b);
      return (b == SEP_SPACE) || (b == SEP_TAB) || (b == SEP_LF) || (b == SEP_CR);
   endfunction

endpackage

[src/rrd_token_track.sv]
// Short token run tracker: open token, previous token and run counters.
module rrd_token_track #(
   parameter int SHORT_TOKEN_MAX = rrd_pkg::SHORT_TOKEN_MAX_DEF,
   parameter int COUNT_BITS      = rrd_pkg::COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  rrd_pkg::req_word_type word,
   output logic [COUNT_BITS-1:0] run_best
);
   import rrd_pkg::*;

   localparam int TB = 8 * SHORT_TOKEN_MAX;
   localparam int LB = $clog2(SHORT_TOKEN_MAX + 2);

   typedef struct packed {
      logic [TB-1:0]         bytes_now;
      logic [LB-1:0]         len_now;
      logic [TB-1:0]         bytes_before;
      logic [LB-1:0]         len_before;
      logic [COUNT_BITS-1:0] run_now;
      logic [COUNT_BITS-1:0] run_best;
   } tok_state_type;

   tok_state_type state_ff;
   tok_state_type state_in;
   tok_state_type after_byte;
   tok_state_type after_last;

   // Closing a token updates the token run and opens an empty token.
   function automatic tok_state_type close_tok(tok_state_type s);
      tok_state_type r;
      r = s;
      if (s.len_now != '0) begin
         if (s.len_now > LB'(SHORT_TOKEN_MAX)) begin
            r.len_before   = '0;
            r.bytes_before = '0;
            r.run_now      = '0;
         end else if ((s.len_before == s.len_now) && (s.bytes_before == s.bytes_now)) begin
            r.run_now = (s.run_now == '1) ? s.run_now : s.run_now + 1'b1;
         end else begin
            r.run_now      = COUNT_BITS'(1);
            r.bytes_before = s.bytes_now;
            r.len_before   = s.len_now;
         end
         if (r.run_now > r.run_best) begin
            r.run_best = r.run_now;
         end
         r.bytes_now = '0;
         r.len_now   = '0;
      end
      return r;
   endfunction

   always_comb begin
      after_byte = state_ff;
      if (is_separator(word.text_byte)) begin
         after_byte = close_tok(state_ff);
      end else if (state_ff.len_now < LB'(SHORT_TOKEN_MAX)) begin
         for (int i = 0; i < SHORT_TOKEN_MAX; i++) begin
            if (state_ff.len_now == LB'(i)) begin
               after_byte.bytes_now[8*i +: 8] = word.text_byte;
            end
         end
         after_byte.len_now = state_ff.len_now + 1'b1;
      end else begin
         after_byte.len_now = LB'(SHORT_TOKEN_MAX + 1);
      end
      after_last = close_tok(after_byte);
      run_best   = after_last.run_best;
      state_in   = state_ff;
      if (step) begin
         state_in = word.is_last ? '0 : after_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/repetition_run_detector.sv]
// Top level of the repetition run detector: byte runs, result buffer, limits.
// Throughput: one text word per cycle; req_ready drops only while two results wait.
// A result reaches rsp_valid in the cycle after its last word is accepted,
// unless an earlier result still waits, in which case it queues behind that one.
// Non-last words produce no result and are accepted even while one result waits.
// Reset clears all text state and the result buffer and loads limits of 35 and 8.
module repetition_run_detector #(
   parameter int SHORT_TOKEN_MAX = rrd_pkg::SHORT_TOKEN_MAX_DEF,
   parameter int COUNT_BITS      = rrd_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rrd_pkg::req_word_type             req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rrd_pkg::rsp_word_type             rsp_word,
   input  logic                              csr_write_enable,
   input  rrd_pkg::csr_index_type            csr_index,
   input  logic [rrd_pkg::OUT_BITS-1:0]      csr_write_data
);
   import rrd_pkg::*;

   localparam int CMP_BITS = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

   logic [OUT_BITS-1:0]   char_limit_ff;
   logic [OUT_BITS-1:0]   token_limit_ff;
   logic [7:0]            prev_byte_ff;
   logic [7:0]            prev_byte_in;
   logic                  have_prev_ff;
   logic                  have_prev_in;
   logic [COUNT_BITS-1:0] byte_run_now_ff;
   logic [COUNT_BITS-1:0] byte_run_now_in;
   logic [COUNT_BITS-1:0] byte_run_best_ff;
   logic [COUNT_BITS-1:0] byte_run_best_in;
   logic [COUNT_BITS-1:0] run_step;
   logic [COUNT_BITS-1:0] best_step;
   logic [COUNT_BITS-1:0] token_best;
   logic [CMP_BITS-1:0]   byte_wide;
   logic [CMP_BITS-1:0]   token_wide;
   rsp_word_type          result;
   rsp_word_type          out_ff;
   rsp_word_type          out_in;
   rsp_word_type          skid_ff;
   rsp_word_type          skid_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic                  skid_valid_ff;
   logic                  skid_valid_in;
   logic                  accept;
   logic                  pop;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   rrd_token_track #(
      .SHORT_TOKEN_MAX(SHORT_TOKEN_MAX),
      .COUNT_BITS     (COUNT_BITS)
   ) u_token (
      .clock   (clock),
      .reset   (reset),
      .step    (accept),
      .word    (req_word),
      .run_best(token_best)
   );

   always_comb begin
      if (have_prev_ff && (prev_byte_ff == req_word.text_byte)) begin
         run_step = (byte_run_now_ff == '1) ? byte_run_now_ff : byte_run_now_ff + 1'b1;
      end else begin
         run_step = COUNT_BITS'(1);
      end
      best_step = (run_step > byte_run_best_ff) ? run_step : byte_run_best_ff;

      byte_wide  = CMP_BITS'(best_step);
      token_wide = CMP_BITS'(token_best);
      result.longest_byte_run = (byte_wide > CMP_BITS'(16'hFFFF)) ?
                                16'hFFFF : byte_wide[OUT_BITS-1:0];
      result.longest_token_repeat = (token_wide > CMP_BITS'(16'hFFFF)) ?
                                    16'hFFFF : token_wide[OUT_BITS-1:0];
      result.is_degenerate = (byte_wide > CMP_BITS'(char_limit_ff)) ||
                             (token_wide > CMP_BITS'(token_limit_ff));

      prev_byte_in     = prev_byte_ff;
      have_prev_in     = have_prev_ff;
      byte_run_now_in  = byte_run_now_ff;
      byte_run_best_in = byte_run_best_ff;
      if (accept) begin
         if (req_word.is_last) begin
            prev_byte_in     = '0;
            have_prev_in     = 1'b0;
            byte_run_now_in  = '0;
            byte_run_best_in = '0;
         end else begin
            prev_byte_in     = req_word.text_byte;
            have_prev_in     = 1'b1;
            byte_run_now_in  = run_step;
            byte_run_best_in = best_step;
         end
      end

      // The skid word moves forward when the output word is taken.
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (accept && req_word.is_last) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_in       = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_limit_ff    <= BYTE_RUN_LIMIT_RESET;
         token_limit_ff   <= TOKEN_RUN_LIMIT_RESET;
         prev_byte_ff     <= '0;
         have_prev_ff     <= 1'b0;
         byte_run_now_ff  <= '0;
         byte_run_best_ff <= '0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_BYTE_RUN_LIMIT:  char_limit_ff  <= csr_write_data;
               CSR_TOKEN_RUN_LIMIT: token_limit_ff <= csr_write_data;
               default: ;
            endcase
         end
         prev_byte_ff     <= prev_byte_in;
         have_prev_ff     <= have_prev_in;
         byte_run_now_ff  <= byte_run_now_in;
         byte_run_best_ff <= byte_run_best_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // The skid word is only ever occupied behind an occupied output word.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held without an output word");

   // A last word always leaves a result waiting in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.is_last) |=> rsp_valid)
      else $error("last word accepted but no result pending");

   // A last word clears the byte run state for the next text.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.is_last) |=> (!have_prev_ff && byte_run_best_ff == '0))
      else $error("byte run state not cleared after last word");

   // The best byte run never falls below the current run within a text.
   assert property (@(posedge clock) disable iff (reset)
      byte_run_best_ff >= byte_run_now_ff)
      else $error("best byte run below current run");

endmodule
